// File: hdl/pfe_pkg.sv
package pfe_pkg;

   // Defaults for the top-level parameters
   localparam int ENTRIES_DEF    = 64;
   localparam int FADE_TICKS_DEF = 22;

   // Field widths
   localparam int CH_W    = 8;
   localparam int IDX_W   = 6;
   localparam int KIND_W  = 3;
   localparam int BANK_W  = 2;
   localparam int RTYPE_W = 2;

   // Channel arithmetic constants
   localparam logic [CH_W-1:0]  STEP      = 8'd32;
   localparam logic [CH_W-1:0]  WHITE     = 8'd224;
   localparam logic [CH_W-1:0]  BLACK     = 8'd0;
   localparam logic [IDX_W-1:0] RANGE_CAP = 6'd63;
   localparam logic [IDX_W-1:0] FULL_FIRST  = 6'd0;
   localparam logic [IDX_W-1:0] FULL_OFFSET = 6'd63;

   // Bank codes
   localparam logic [BANK_W-1:0] BANK_CUR_A = 2'd0;
   localparam logic [BANK_W-1:0] BANK_TGT_A = 2'd1;
   localparam logic [BANK_W-1:0] BANK_CUR_B = 2'd2;
   localparam logic [BANK_W-1:0] BANK_TGT_B = 2'd3;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] CSR_IDX_SKIP = 1'b0;

   typedef enum logic [RTYPE_W-1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_START = 2'd2,
      REQ_TICK  = 2'd3
   } req_kind_type;

   typedef enum logic [KIND_W-1:0] {
      MODE_NONE      = 3'd0,
      MODE_FADE_IN   = 3'd1,
      MODE_FADE_OUT  = 3'd2,
      MODE_FLASH_IN  = 3'd3,
      MODE_FLASH_OUT = 3'd4
   } fade_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_WALK,
      ST_DRAIN,
      ST_READ,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic [CH_W-1:0] r;
      logic [CH_W-1:0] g;
      logic [CH_W-1:0] b;
   } rgb_type;

   // One fade step of a current entry: toward its target for fade-in and flash-in, toward black or white otherwise
   function automatic rgb_type step_entry(input fade_mode_type mode, input rgb_type cur,
                                          input rgb_type tgt);
      rgb_type nxt;
      nxt = cur;
      case (mode)
         MODE_FADE_IN: begin
            if (tgt.b > cur.b) nxt.b = cur.b + STEP;
            else if (tgt.g > cur.g) nxt.g = cur.g + STEP;
            else if (tgt.r > cur.r) nxt.r = cur.r + STEP;
         end
         MODE_FLASH_IN: begin
            if (tgt.b < cur.b) nxt.b = cur.b - STEP;
            else if (tgt.g < cur.g) nxt.g = cur.g - STEP;
            else if (tgt.r < cur.r) nxt.r = cur.r - STEP;
         end
         MODE_FADE_OUT: begin
            if (cur.r != BLACK) nxt.r = cur.r - STEP;
            else if (cur.g != BLACK) nxt.g = cur.g - STEP;
            else if (cur.b != BLACK) nxt.b = cur.b - STEP;
         end
         default: begin
            if (cur.r != WHITE) nxt.r = cur.r + STEP;
            else if (cur.g != WHITE) nxt.g = cur.g + STEP;
            else if (cur.b != WHITE) nxt.b = cur.b + STEP;
         end
      endcase
      return nxt;
   endfunction

endpackage

// File: hdl/pfe_req_if.sv
interface pfe_req_if;
   logic                          valid;
   logic                          ready;
   logic [pfe_pkg::RTYPE_W-1:0]   req_type;
   logic [pfe_pkg::BANK_W-1:0]    bank;
   logic [pfe_pkg::IDX_W-1:0]     entry_index;
   logic [pfe_pkg::CH_W-1:0]      red_in;
   logic [pfe_pkg::CH_W-1:0]      green_in;
   logic [pfe_pkg::CH_W-1:0]      blue_in;
   logic [pfe_pkg::KIND_W-1:0]    fade_kind;
   logic [pfe_pkg::IDX_W-1:0]     first_entry;
   logic [pfe_pkg::IDX_W-1:0]     last_offset;

   modport source (
      output valid, req_type, bank, entry_index, red_in, green_in, blue_in,
             fade_kind, first_entry, last_offset,
      input  ready
   );

   modport sink (
      input  valid, req_type, bank, entry_index, red_in, green_in, blue_in,
             fade_kind, first_entry, last_offset,
      output ready
   );
endinterface

// File: hdl/pfe_rsp_if.sv
interface pfe_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [pfe_pkg::CH_W-1:0] red_out;
   logic [pfe_pkg::CH_W-1:0] green_out;
   logic [pfe_pkg::CH_W-1:0] blue_out;
   logic                     fade_done;

   modport source (
      output valid, red_out, green_out, blue_out, fade_done,
      input  ready
   );

   modport sink (
      input  valid, red_out, green_out, blue_out, fade_done,
      output ready
   );
endinterface

// File: hdl/palette_fade_engine_core.sv
// Writes, starts and idle ticks go from IDLE to FINISH, reads through READ, and a fade-in or
// flash-in start first paints its entries of current bank A in FILL. A frame tick walks its
// range in WALK, bank A then bank B (bank B skipped in fade-in and flash-in modes while
// skip_second_bank is set), then DRAIN and FINISH: the single RAM read-modify-write pipeline
// steps one entry a cycle. One transaction at a time; FINISH waits for the result register.
// Reset is synchronous, active high, clears mode, counter, range and handshakes; no RAM clear.
module palette_fade_engine_core #(
   parameter int ENTRIES    = pfe_pkg::ENTRIES_DEF,
   parameter int FADE_TICKS = pfe_pkg::FADE_TICKS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   pfe_req_if.sink                            req_ch,
   pfe_rsp_if.source                          rsp_ch,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pfe_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [pfe_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [pfe_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   localparam int ADDR_W = $clog2(4 * ENTRIES);

   logic               skip_second_bank;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   pfe_pkg::rgb_type   wr_data;
   logic [ADDR_W-1:0]  rd_addr_a;
   logic [ADDR_W-1:0]  rd_addr_b;
   pfe_pkg::rgb_type   rd_data_a;
   pfe_pkg::rgb_type   rd_data_b;

   pfe_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .skip_second_bank (skip_second_bank)
   );

   pfe_palette_ram #(
      .ENTRIES (ENTRIES)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   pfe_sequencer #(
      .ENTRIES    (ENTRIES),
      .FADE_TICKS (FADE_TICKS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .skip_second_bank (skip_second_bank),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_addr_a        (rd_addr_a),
      .rd_addr_b        (rd_addr_b),
      .rd_data_a        (rd_data_a),
      .rd_data_b        (rd_data_b)
   );

`ifndef SYNTHESIS
   // One transaction at a time: ready drops right after an acceptance
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while busy");

   // A new result is loaded only while the sequencer is busy
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(!req_ch.ready))
      else $error("result appeared without a transaction in flight");

   // Done is reported only by ticks, which carry no color
   a_done_no_color: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.fade_done |->
         rsp_ch.red_out == '0 && rsp_ch.green_out == '0 && rsp_ch.blue_out == '0)
      else $error("fade_done with nonzero color");
`endif

endmodule

// File: hdl/pfe_palette_ram.sv
module pfe_palette_ram #(
   parameter  int ENTRIES = pfe_pkg::ENTRIES_DEF,
   localparam int DEPTH   = 4 * ENTRIES,
   localparam int ADDR_W  = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  pfe_pkg::rgb_type    wr_data,
   input  logic [ADDR_W-1:0]   rd_addr_a,
   input  logic [ADDR_W-1:0]   rd_addr_b,
   output pfe_pkg::rgb_type    rd_data_a,
   output pfe_pkg::rgb_type    rd_data_b
);

   pfe_pkg::rgb_type mem [DEPTH];

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register both read ports
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// File: hdl/pfe_csr.sv
module pfe_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [pfe_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [pfe_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [pfe_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output logic                               skip_second_bank
);

   logic skip_ff;
   logic skip_in;
   logic hit;

   // Decode the register word from the byte address
   assign hit = (paddr[pfe_pkg::CSR_ADDR_W-1:2] == pfe_pkg::CSR_IDX_SKIP);

   always_comb begin
      skip_in = skip_ff;
      if (psel && penable && pwrite && hit) begin
         skip_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= 1'b0;
      end else begin
         skip_ff <= skip_in;
      end
   end

   assign pready           = 1'b1;
   assign prdata           = hit ? {{(pfe_pkg::CSR_DATA_W-1){1'b0}}, skip_ff}
                                 : '0;
   assign skip_second_bank = skip_ff;

endmodule

// File: hdl/pfe_sequencer.sv
module pfe_sequencer #(
   parameter  int ENTRIES    = pfe_pkg::ENTRIES_DEF,
   parameter  int FADE_TICKS = pfe_pkg::FADE_TICKS_DEF,
   localparam int DEPTH      = 4 * ENTRIES,
   localparam int ADDR_W     = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                skip_second_bank,
   pfe_req_if.sink             req,
   pfe_rsp_if.source           rsp,
   output logic                wr_en,
   output logic [ADDR_W-1:0]   wr_addr,
   output pfe_pkg::rgb_type    wr_data,
   output logic [ADDR_W-1:0]   rd_addr_a,
   output logic [ADDR_W-1:0]   rd_addr_b,
   input  pfe_pkg::rgb_type    rd_data_a,
   input  pfe_pkg::rgb_type    rd_data_b
);

   localparam int TICK_W = $clog2(FADE_TICKS);
   localparam int SUM_W  = pfe_pkg::IDX_W + 1;
   localparam int LAST_ENTRY = (ENTRIES - 1 < int'(pfe_pkg::RANGE_CAP)) ?
                               ENTRIES - 1 : int'(pfe_pkg::RANGE_CAP);
   localparam logic [SUM_W-1:0]  LAST_CAP  = SUM_W'(LAST_ENTRY);
   localparam logic [ADDR_W-1:0] BANK_SPAN = ADDR_W'(ENTRIES);
   localparam logic [ADDR_W-1:0] BASE_CUR_B =
      ADDR_W'(int'(pfe_pkg::BANK_CUR_B) * ENTRIES);
   localparam logic [ADDR_W-1:0] BASE_CUR_A =
      ADDR_W'(int'(pfe_pkg::BANK_CUR_A) * ENTRIES);

   pfe_pkg::seq_state_type   state_ff, state_in;
   pfe_pkg::fade_mode_type   mode_ff, mode_in;
   logic [TICK_W-1:0]        tick_ff, tick_in;
   logic [pfe_pkg::IDX_W-1:0] first_ff, first_in;
   logic [pfe_pkg::IDX_W-1:0] offset_ff, offset_in;
   logic [pfe_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                     second_ff, second_in;
   logic [pfe_pkg::CH_W-1:0] fill_ff, fill_in;
   logic                     wb_valid_ff, wb_valid_in;
   logic [ADDR_W-1:0]        wb_addr_ff, wb_addr_in;
   pfe_pkg::rgb_type         res_ff, res_in;
   logic                     res_done_ff, res_done_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   pfe_pkg::rgb_type         rsp_data_ff, rsp_data_in;
   logic                     rsp_done_ff, rsp_done_in;

   logic [SUM_W-1:0]          range_sum;
   logic [SUM_W-1:0]          range_end;
   logic [pfe_pkg::IDX_W-1:0] last_idx;
   logic                      range_empty;
   logic                      idx_ok;
   logic                      in_mode;
   logic [ADDR_W-1:0]         item_addr;
   logic [ADDR_W-1:0]         walk_addr;
   logic                      accept;
   pfe_pkg::rgb_type          item_rgb;

   // Clamp the range end to the cap and to the last entry
   assign range_sum   = {1'b0, first_ff} + {1'b0, offset_ff};
   assign range_end   = (range_sum > LAST_CAP) ? LAST_CAP : range_sum;
   assign last_idx    = range_end[pfe_pkg::IDX_W-1:0];
   assign range_empty = ({1'b0, first_ff} > range_end);

   // Entry index check for bus items
   assign idx_ok = (ENTRIES >= 64) ? 1'b1 :
                   (req.entry_index < pfe_pkg::IDX_W'(ENTRIES));

   assign in_mode   = (mode_ff == pfe_pkg::MODE_FADE_IN) ||
                      (mode_ff == pfe_pkg::MODE_FLASH_IN);
   assign item_addr = ADDR_W'(req.bank) * BANK_SPAN + ADDR_W'(req.entry_index);
   assign walk_addr = (second_ff ? BASE_CUR_B : BASE_CUR_A) + ADDR_W'(idx_ff);
   assign accept    = req.valid && req.ready;
   assign item_rgb  = '{r: req.red_in, g: req.green_in, b: req.blue_in};

   // Next state and memory control
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      tick_in      = tick_ff;
      first_in     = first_ff;
      offset_in    = offset_ff;
      idx_in       = idx_ff;
      second_in    = second_ff;
      fill_in      = fill_ff;
      wb_valid_in  = 1'b0;
      wb_addr_in   = wb_addr_ff;
      res_in       = res_ff;
      res_done_in  = res_done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_done_in  = rsp_done_ff;

      req.ready = (state_ff == pfe_pkg::ST_IDLE);

      // Write back the stepped entry read in the previous cycle
      wr_en     = wb_valid_ff;
      wr_addr   = wb_addr_ff;
      wr_data   = pfe_pkg::step_entry(mode_ff, rd_data_a, rd_data_b);
      rd_addr_a = item_addr;
      rd_addr_b = walk_addr + BANK_SPAN;

      case (state_ff)
         pfe_pkg::ST_IDLE: begin
            if (accept) begin
               res_in      = '0;
               res_done_in = 1'b0;
               state_in    = pfe_pkg::ST_FINISH;
               case (req.req_type)
                  pfe_pkg::REQ_WRITE: begin
                     if (idx_ok) begin
                        wr_en   = 1'b1;
                        wr_addr = item_addr;
                        wr_data = item_rgb;
                     end
                  end
                  pfe_pkg::REQ_READ: begin
                     if (idx_ok) begin
                        state_in = pfe_pkg::ST_READ;
                     end
                  end
                  pfe_pkg::REQ_START: begin
                     case (req.fade_kind)
                        pfe_pkg::MODE_FADE_IN: begin
                           first_in  = req.first_entry;
                           offset_in = req.last_offset;
                           idx_in    = req.first_entry;
                           fill_in   = pfe_pkg::BLACK;
                           tick_in   = '0;
                           mode_in   = pfe_pkg::MODE_FADE_IN;
                           state_in  = pfe_pkg::ST_FILL;
                        end
                        pfe_pkg::MODE_FLASH_IN: begin
                           first_in  = pfe_pkg::FULL_FIRST;
                           offset_in = pfe_pkg::FULL_OFFSET;
                           idx_in    = pfe_pkg::FULL_FIRST;
                           fill_in   = pfe_pkg::WHITE;
                           tick_in   = '0;
                           mode_in   = pfe_pkg::MODE_FLASH_IN;
                           state_in  = pfe_pkg::ST_FILL;
                        end
                        pfe_pkg::MODE_FADE_OUT, pfe_pkg::MODE_FLASH_OUT: begin
                           first_in  = pfe_pkg::FULL_FIRST;
                           offset_in = pfe_pkg::FULL_OFFSET;
                           tick_in   = '0;
                           mode_in   = pfe_pkg::fade_mode_type'(req.fade_kind);
                        end
                        default: begin
                        end
                     endcase
                  end
                  default: begin
                     if (mode_ff == pfe_pkg::MODE_NONE) begin
                        res_done_in = 1'b1;
                     end else begin
                        idx_in    = first_ff;
                        second_in = 1'b0;
                        state_in  = pfe_pkg::ST_WALK;
                     end
                  end
               endcase
            end
         end

         // Paint the range of current bank A, one entry a cycle
         pfe_pkg::ST_FILL: begin
            if (range_empty) begin
               state_in = pfe_pkg::ST_FINISH;
            end else begin
               wr_en   = 1'b1;
               wr_addr = BASE_CUR_A + ADDR_W'(idx_ff);
               wr_data = '{r: fill_ff, g: fill_ff, b: fill_ff};
               if (idx_ff == last_idx) begin
                  state_in = pfe_pkg::ST_FINISH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         // Issue one read-modify-write per cycle over the range
         pfe_pkg::ST_WALK: begin
            rd_addr_a = walk_addr;
            if (range_empty) begin
               state_in = pfe_pkg::ST_DRAIN;
            end else begin
               wb_valid_in = 1'b1;
               wb_addr_in  = walk_addr;
               if (idx_ff == last_idx) begin
                  if (!second_ff && !(skip_second_bank && in_mode)) begin
                     second_in = 1'b1;
                     idx_in    = first_ff;
                  end else begin
                     state_in = pfe_pkg::ST_DRAIN;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         // Last write back lands here; advance the tick counter, wrapping and flagging done on its last count
         pfe_pkg::ST_DRAIN: begin
            if (tick_ff == TICK_W'(FADE_TICKS - 1)) begin
               tick_in     = '0;
               res_done_in = 1'b1;
            end else begin
               tick_in     = tick_ff + 1'b1;
               res_done_in = 1'b0;
            end
            state_in = pfe_pkg::ST_FINISH;
         end

         pfe_pkg::ST_READ: begin
            res_in   = rd_data_a;
            state_in = pfe_pkg::ST_FINISH;
         end

         // Hand the result to the output register once it is free
         pfe_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               rsp_done_in  = res_done_ff;
               state_in     = pfe_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pfe_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfe_pkg::ST_IDLE;
         mode_ff      <= pfe_pkg::MODE_NONE;
         tick_ff      <= '0;
         first_ff     <= pfe_pkg::FULL_FIRST;
         offset_ff    <= pfe_pkg::FULL_OFFSET;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         tick_ff      <= tick_in;
         first_ff     <= first_in;
         offset_ff    <= offset_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and walk registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      second_ff   <= second_in;
      fill_ff     <= fill_in;
      wb_addr_ff  <= wb_addr_in;
      res_ff      <= res_in;
      res_done_ff <= res_done_in;
      rsp_data_ff <= rsp_data_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.red_out   = rsp_data_ff.r;
   assign rsp.green_out = rsp_data_ff.g;
   assign rsp.blue_out  = rsp_data_ff.b;
   assign rsp.fade_done = rsp_done_ff;

endmodule
